@@ hdl/flht_pkg.sv @@
// Shared types and constants for the fingerprint location hash table.
package flht_pkg;

    localparam int          DATA_W     = 32;
    localparam int          CFG_W      = 11;
    localparam logic [31:0] HASH_MUL   = 32'h045d_9f3b;
    localparam int          HASH_SHIFT = 16;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_INIT,
        B_IDLE,
        B_HEAD,
        B_KEY,
        B_GET,
        B_SCAN,
        B_APPEND,
        B_NEW,
        B_LINK,
        B_EMIT
    } t_back_state;

    function automatic logic [31:0] fold(input logic [31:0] h);
        return h ^ (h >> HASH_SHIFT);
    endfunction

endpackage

@@ hdl/flht_fifo.sv @@
// Two-entry queue between the hashing front end and the table engine.
module flht_fifo #(
    parameter int W = 75
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule

@@ hdl/flht_front.sv @@
// Front end: takes items, hashes the fingerprint and reduces it to a bucket.
module flht_front
    import flht_pkg::*;
#(
    parameter int BUCKETS = 1024,
    parameter int BW      = 10,
    parameter int NBW     = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [DATA_W-1:0]   i_fingerprint,
    input  logic [DATA_W-1:0]   i_position,
    input  logic                i_init_done,
    output logic                o_push,
    output logic [2*DATA_W+BW:0] o_job,
    input  logic                i_full
);

    localparam logic [NBW-1:0] N_MAX = NBW'(BUCKETS);

    t_front_state       r_state, n_state;
    logic               r_cmd;
    logic [DATA_W-1:0]  r_key;
    logic [DATA_W-1:0]  r_pos;
    logic [31:0]        r_h, n_h;
    logic [NBW-1:0]     r_n;
    logic [NBW-1:0]     r_rem, n_rem;
    logic [4:0]         r_dcnt;
    logic [NBW:0]       rem_sh;
    logic [31:0]        cfg32;
    logic               accept;

    assign accept = i_in_valid && o_in_ready;
    assign cfg32  = 32'(i_cfg_data);
    assign rem_sh = {r_rem, r_h[31]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (accept) n_state = F_MUL1;
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_DIV;
            F_DIV:  if (r_dcnt == 5'd31) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_h   = r_h;
        n_rem = r_rem;
        case (r_state)
            F_IDLE: n_h = i_fingerprint;
            F_MUL1: n_h = fold(r_h) * HASH_MUL;
            F_MUL2: n_h = fold(fold(r_h) * HASH_MUL);
            F_DIV: begin
                // restoring remainder, one quotient bit per cycle
                n_h = r_h << 1;
                if (rem_sh >= {1'b0, r_n}) begin
                    n_rem = NBW'(rem_sh - {1'b0, r_n});
                end else begin
                    n_rem = NBW'(rem_sh);
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == F_IDLE) && i_init_done;
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_job      = {r_cmd, r_key, r_pos, BW'(r_rem)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_n     <= N_MAX;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (cfg32 == 32'd0) begin
                    r_n <= NBW'(1);
                end else if (cfg32 > BUCKETS) begin
                    r_n <= N_MAX;
                end else begin
                    r_n <= NBW'(i_cfg_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h   <= n_h;
        r_rem <= (r_state == F_MUL2) ? '0 : n_rem;
        r_dcnt <= (r_state == F_DIV) ? r_dcnt + 5'd1 : 5'd0;
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= i_fingerprint;
            r_pos <= i_position;
        end
    end

endmodule

@@ hdl/flht_back.sv @@
// Table engine: bucket heads, entry chains and location lists in memory.
module flht_back
    import flht_pkg::*;
#(
    parameter int BUCKETS  = 1024,
    parameter int ENTRIES  = 1024,
    parameter int MAX_LOCS = 16,
    parameter int BW       = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  logic [2*DATA_W+BW:0] i_job,
    output logic                 o_job_pop,
    output logic                 o_init_done,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [DATA_W-1:0]    o_position_out,
    output logic                 o_last,
    output logic                 o_dropped
);

    localparam int EW   = $clog2(ENTRIES + 1);
    localparam int EIW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW   = $clog2(MAX_LOCS + 1);
    localparam int LIW  = (MAX_LOCS > 1) ? $clog2(MAX_LOCS) : 1;
    localparam int AW   = (ENTRIES * MAX_LOCS > 1) ? $clog2(ENTRIES * MAX_LOCS) : 1;
    localparam logic [EW-1:0] NIL   = EW'(ENTRIES);
    localparam logic [LW-1:0] LMAX  = LW'(MAX_LOCS);
    localparam logic [AW-1:0] LSTEP = AW'(MAX_LOCS);

    // memories
    logic [EW-1:0]     head_mem [BUCKETS];
    logic [DATA_W-1:0] key_mem  [ENTRIES];
    logic [EW-1:0]     next_mem [ENTRIES];
    logic [LW-1:0]     cnt_mem  [ENTRIES];
    logic [DATA_W-1:0] loc_mem  [ENTRIES * MAX_LOCS];

    logic [EW-1:0]     head_q;
    logic [DATA_W-1:0] key_q;
    logic [EW-1:0]     next_q;
    logic [LW-1:0]     cnt_q;
    logic [DATA_W-1:0] loc_q;

    logic              head_we;
    logic [BW-1:0]     head_wa;
    logic [EW-1:0]     head_wd;
    logic              ent_we;
    logic              next_we;
    logic [EIW-1:0]    next_wa;
    logic [EW-1:0]     next_wd;
    logic              cnt_we;
    logic [EIW-1:0]    cnt_wa;
    logic [LW-1:0]     cnt_wd;
    logic              loc_we;
    logic [AW-1:0]     loc_wa;
    logic [AW-1:0]     loc_ra;

    t_back_state       r_state, n_state;
    logic              r_cmd;
    logic [DATA_W-1:0] r_key;
    logic [DATA_W-1:0] r_pos;
    logic [BW-1:0]     r_bkt;
    logic [EW-1:0]     r_cur, n_cur;
    logic [EW-1:0]     r_tail, n_tail;
    logic [EW-1:0]     r_steps, n_steps;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic [LIW-1:0]    r_i, n_i;
    logic [AW-1:0]     r_base, n_base;
    logic [EW-1:0]     r_used;
    logic              r_res_hit, n_res_hit;
    logic              r_res_drop, n_res_drop;
    logic [BW-1:0]     r_init;

    logic              can_out;
    logic              load_out;
    logic              out_hit, out_last, out_drop;
    logic [DATA_W-1:0] out_pos;
    logic              key_match;
    logic              chain_more;
    logic              idx_last;
    logic              new_full;

    assign can_out    = !o_out_valid || i_out_ready;
    assign key_match  = (key_q == r_key);
    assign chain_more = (next_q < NIL) && (32'(r_steps) + 1 < ENTRIES);
    assign idx_last   = (LW'(r_i) + LW'(1) == r_cnt);
    assign new_full   = (32'(r_used) >= ENTRIES);
    assign o_job_pop  = (r_state == B_IDLE) && i_job_valid;
    assign o_init_done = (r_state != B_INIT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_INIT: if (r_init == BW'(BUCKETS - 1)) n_state = B_IDLE;
            B_IDLE: if (i_job_valid) n_state = B_HEAD;
            B_HEAD: begin
                if (head_q < NIL) begin
                    n_state = B_KEY;
                end else if (r_cmd == CMD_GET) begin
                    n_state = B_EMIT;
                end else begin
                    n_state = B_NEW;
                end
            end
            B_KEY: begin
                if (key_match) begin
                    if (r_cmd == CMD_GET) begin
                        n_state = (cnt_q == '0) ? B_EMIT : B_GET;
                    end else begin
                        n_state = (cnt_q == '0) ? B_APPEND : B_SCAN;
                    end
                end else if (!chain_more) begin
                    n_state = (r_cmd == CMD_GET) ? B_EMIT : B_NEW;
                end
            end
            B_GET:    if (can_out && idx_last) n_state = B_IDLE;
            B_SCAN: begin
                if (loc_q == r_pos) begin
                    n_state = B_EMIT;
                end else if (idx_last) begin
                    n_state = B_APPEND;
                end
            end
            B_APPEND: n_state = B_EMIT;
            B_NEW:    n_state = new_full ? B_EMIT : B_LINK;
            B_LINK:   n_state = B_EMIT;
            B_EMIT:   if (can_out) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    // datapath, memory controls and result
    always_comb begin
        n_cur      = r_cur;
        n_tail     = r_tail;
        n_steps    = r_steps;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_base     = r_base;
        n_res_hit  = r_res_hit;
        n_res_drop = r_res_drop;
        head_we    = 1'b0;
        head_wa    = r_bkt;
        head_wd    = r_cur;
        ent_we     = 1'b0;
        next_we    = 1'b0;
        next_wa    = r_cur[EIW-1:0];
        next_wd    = NIL;
        cnt_we     = 1'b0;
        cnt_wa     = r_cur[EIW-1:0];
        cnt_wd     = r_cnt + LW'(1);
        loc_we     = 1'b0;
        loc_wa     = r_base + AW'(r_cnt);
        load_out   = 1'b0;
        out_hit    = 1'b1;
        out_pos    = '0;
        out_last   = 1'b1;
        out_drop   = 1'b0;
        case (r_state)
            B_INIT: begin
                head_we = 1'b1;
                head_wa = r_init;
                head_wd = NIL;
            end
            B_HEAD: begin
                n_cur      = head_q;
                n_tail     = NIL;
                n_steps    = '0;
                n_res_hit  = 1'b0;
                n_res_drop = 1'b0;
            end
            B_KEY: begin
                if (key_match) begin
                    n_cnt     = cnt_q;
                    n_i       = '0;
                    n_base    = AW'(r_cur[EIW-1:0]) * LSTEP;
                    n_res_hit = 1'b1;
                end else begin
                    n_tail  = r_cur;
                    n_cur   = next_q;
                    n_steps = r_steps + EW'(1);
                end
            end
            B_GET: begin
                if (can_out) begin
                    load_out = 1'b1;
                    out_pos  = loc_q;
                    out_last = idx_last;
                    n_i      = r_i + LIW'(1);
                end
            end
            B_SCAN: begin
                if (loc_q != r_pos && !idx_last) begin
                    n_i = r_i + LIW'(1);
                end
            end
            B_APPEND: begin
                if (r_cnt == LMAX) begin
                    n_res_drop = 1'b1;
                end else begin
                    loc_we = 1'b1;
                    cnt_we = 1'b1;
                end
            end
            B_NEW: begin
                if (new_full) begin
                    n_res_drop = 1'b1;
                end else begin
                    ent_we  = 1'b1;
                    next_we = 1'b1;
                    next_wa = r_used[EIW-1:0];
                    cnt_we  = 1'b1;
                    cnt_wa  = r_used[EIW-1:0];
                    cnt_wd  = LW'(1);
                    loc_we  = 1'b1;
                    loc_wa  = AW'(r_used[EIW-1:0]) * LSTEP;
                    n_cur   = r_used;
                end
            end
            B_LINK: begin
                if (r_tail == NIL) begin
                    head_we = 1'b1;
                end else begin
                    next_we = 1'b1;
                    next_wa = r_tail[EIW-1:0];
                    next_wd = r_cur;
                end
            end
            B_EMIT: begin
                if (can_out) begin
                    load_out = 1'b1;
                    out_hit  = r_res_hit;
                    out_drop = r_res_drop;
                end
            end
            default: ;
        endcase
    end

    // read addresses follow the next-state values, data comes next cycle
    assign loc_ra = n_base + AW'(n_i);

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_q <= head_mem[i_job[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            key_mem[r_used[EIW-1:0]] <= r_key;
        end
        key_q <= key_mem[n_cur[EIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[n_cur[EIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        cnt_q <= cnt_mem[n_cur[EIW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (loc_we) begin
            loc_mem[loc_wa] <= r_pos;
        end
        loc_q <= loc_mem[loc_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_init      <= '0;
            r_used      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_INIT) begin
                r_init <= r_init + BW'(1);
            end
            if (r_state == B_NEW && !new_full) begin
                r_used <= r_used + EW'(1);
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_tail     <= n_tail;
        r_steps    <= n_steps;
        r_cnt      <= n_cnt;
        r_i        <= n_i;
        r_base     <= n_base;
        r_res_hit  <= n_res_hit;
        r_res_drop <= n_res_drop;
        if (o_job_pop) begin
            {r_cmd, r_key, r_pos, r_bkt} <= i_job;
        end
        if (load_out) begin
            o_hit          <= out_hit;
            o_position_out <= out_pos;
            o_last         <= out_last;
            o_dropped      <= out_drop;
        end
    end

endmodule

@@ hdl/fingerprint_location_hash_table.sv @@
// Fingerprint location hash table: top level.
// Input channel i_in_valid/o_in_ready moves one command per transfer: add
// (i_cmd 0) stores i_position under i_fingerprint, get (i_cmd 1) looks it up.
// Output channel o_out_valid/i_out_ready moves result transfers: one per add
// or get miss, one per stored position on a get hit, o_last on the final one.
// i_cfg_we writes the bucket count (0 acts as 1, above BUCKETS saturates).
// Front end: two 32x32 hash multiplies, then a bit-serial remainder by
// the bucket count; it takes a new item only after pushing the last. It
// hands off to the table engine through a two-entry queue, so it hashes
// the next item while the engine works on the previous one.
// Table engine: reads the bucket head, walks the chain one entry at a time,
// scans or streams stored positions one at a time, then writes any update.
// Memory reads are registered.
// After reset the engine clears the bucket heads, one per cycle; no input
// is taken until that pass ends.
// A stalled receiver holds the output register; the engine waits on it and
// the queue and front end fill up behind it, and o_in_ready stays low.
module fingerprint_location_hash_table
    import flht_pkg::*;
#(
    parameter int BUCKETS  = 1024,
    parameter int ENTRIES  = 1024,
    parameter int MAX_LOCS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_cmd,
    input  logic [DATA_W-1:0]   i_fingerprint,
    input  logic [DATA_W-1:0]   i_position,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_hit,
    output logic [DATA_W-1:0]   o_position_out,
    output logic                o_last,
    output logic                o_dropped
);

    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NBW = $clog2(BUCKETS + 1);
    localparam int JW  = 2 * DATA_W + BW + 1;

    logic          init_done;
    logic          push;
    logic          full;
    logic          pop;
    logic          job_valid;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;

    flht_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW),
        .NBW     (NBW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_fingerprint (i_fingerprint),
        .i_position    (i_position),
        .i_init_done   (init_done),
        .o_push        (push),
        .o_job         (job_in),
        .i_full        (full)
    );

    flht_fifo #(
        .W (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job_out)
    );

    flht_back #(
        .BUCKETS  (BUCKETS),
        .ENTRIES  (ENTRIES),
        .MAX_LOCS (MAX_LOCS),
        .BW       (BW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (job_out),
        .o_job_pop      (pop),
        .o_init_done    (init_done),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_position_out (o_position_out),
        .o_last         (o_last),
        .o_dropped      (o_dropped)
    );

endmodule
